// ===== rtl/pausable_frame_timer_top_defines.svh =====
// assertion macros shared by the pausable frame timer rtl
// depends on: a clk and an active-low arst_n in the using module
`ifndef PAUSABLE_FRAME_TIMER_TOP_DEFINES_SVH
`define PAUSABLE_FRAME_TIMER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define PFT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define PFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pft_pkg.sv =====
// shared types and constants for the pausable frame timer
// depends on: nothing
package pft_pkg;

	localparam int TS_W          = 64;
	localparam int CPS_W         = 32;
	localparam int FRM_W         = 32;
	localparam int FPS_FRAC_BITS = 8;
	localparam int FPS_W         = 24;
	localparam int OP_W          = 2;
	localparam int PADDR_W       = 3;
	localparam int PDATA_W       = 32;
	localparam int REG_IDX_LSB   = 2;
	localparam int REG_IDX_W     = PADDR_W - REG_IDX_LSB;

	localparam logic [CPS_W-1:0] CPS_RESET = CPS_W'(10000000);
	localparam logic [FPS_W-1:0] FPS_MAX   = {FPS_W{1'b1}};

	// register index of counts_per_second
	localparam logic [REG_IDX_W-1:0] REG_CPS = '0;

	// divider: one quotient bit per cycle over the scaled numerator
	localparam int DIV_STEPS = TS_W + FPS_FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_START = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ACCUM,
		S_CHECK,
		S_DIVSTART,
		S_DIV,
		S_DIVEND,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic accum;
		logic check;
		logic div_start;
		logic div_end;
		logic finish;
	} pft_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic close;
		logic div_busy;
		logic div_done;
		logic out_free;
	} pft_sts_t;

endpackage

// ===== rtl/pft_div.sv =====
// restoring divider for the frame rate, one quotient bit per cycle
// depends on: pft_pkg
module pft_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pft_pkg::TS_W-1:0]  num,
	input  logic [pft_pkg::TS_W-1:0]  den,
	output logic                      busy,
	output logic                      done,
	output logic [pft_pkg::FPS_W-1:0] quot,
	output logic                      ovf
);
	import pft_pkg::*;

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_STEPS-1:0] dvd_q;
	logic [TS_W-1:0]      den_q;
	logic [TS_W-1:0]      rem_q;
	logic [FPS_W-1:0]     quot_q;
	logic                 ovf_q;
	logic [TS_W:0]        trial;
	logic [TS_W:0]        diff;
	logic                 ge;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {rem_q, dvd_q[DIV_STEPS-1]};
		diff  = trial - {1'b0, den_q};
		ge    = !diff[TS_W];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	// remainder, quotient and overflow of the bits above the result width
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {num, {FPS_FRAC_BITS{1'b0}}};
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DIV_STEPS-2:0], 1'b0};
			rem_q  <= ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
			quot_q <= {quot_q[FPS_W-2:0], ge};
			ovf_q  <= ovf_q | quot_q[FPS_W-1];
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == CNT_W'(1));
	assign quot = quot_q;
	assign ovf  = ovf_q;

endmodule

// ===== rtl/pft_dp.sv =====
// timer datapath: event state, frame window, output register
// depends on: pft_pkg, pft_div
module pft_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pft_pkg::pft_cmd_t         cmd,
	output pft_pkg::pft_sts_t         sts,
	input  logic [pft_pkg::CPS_W-1:0] cps,
	input  logic [pft_pkg::OP_W-1:0]  opcode,
	input  logic [pft_pkg::TS_W-1:0]  timestamp,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [pft_pkg::TS_W-1:0]  delta_counts,
	output logic [pft_pkg::TS_W-1:0]  total_counts,
	output logic [pft_pkg::FPS_W-1:0] fps_fixed,
	output logic                      is_paused
);
	import pft_pkg::*;

	// captured item
	op_t             op_q;
	logic [TS_W-1:0] ts_q;

	// timer state
	logic [TS_W-1:0]  base_q;
	logic [TS_W-1:0]  prev_q;
	logic [TS_W-1:0]  last_tick_q;
	logic [TS_W-1:0]  stop_q;
	logic [TS_W-1:0]  paused_q;
	logic             stopped_q;
	logic [FRM_W-1:0] frames_q;
	logic [TS_W-1:0]  window_q;
	logic [FPS_W-1:0] fps_q;

	// per-item scratch
	logic             do_tick_q;
	logic             do_start_q;
	logic [TS_W-1:0]  span_q;
	logic [TS_W-1:0]  delta_q;
	logic [TS_W-1:0]  rmb_q;
	logic [TS_W-1:0]  total_q;
	logic [TS_W-1:0]  prod_q;
	logic [TS_W-1:0]  den_q;
	logic             res_valid_q;

	logic [TS_W-1:0]  span_ref;
	logic [TS_W-1:0]  span_pos;
	logic [TS_W:0]    win_sum;
	logic             div_busy;
	logic             div_done;
	logic [FPS_W-1:0] div_quot;
	logic             div_ovf;

	// operand of the span subtract and the clamped span
	always_comb begin
		span_ref = (op_q == OP_START) ? stop_q : prev_q;
		span_pos = span_q[TS_W-1] ? '0 : span_q;
		win_sum  = {1'b0, window_q} + {1'b0, span_pos};
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(opcode);
			ts_q <= timestamp;
		end
	end

	// architectural timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			prev_q      <= '0;
			last_tick_q <= '0;
			stop_q      <= '0;
			paused_q    <= '0;
			stopped_q   <= 1'b0;
			frames_q    <= '0;
			window_q    <= '0;
			fps_q       <= '0;
			do_tick_q   <= 1'b0;
			do_start_q  <= 1'b0;
		end else begin
			// event update
			if (cmd.exec) begin
				do_tick_q  <= (op_q == OP_TICK) && !stopped_q;
				do_start_q <= (op_q == OP_START) && stopped_q;
				case (op_q)
					OP_TICK: begin
						if (!stopped_q) begin
							last_tick_q <= ts_q;
							prev_q      <= ts_q;
							if (frames_q != '1)
								frames_q <= frames_q + 1'b1;
						end
					end
					OP_RESET: begin
						base_q    <= ts_q;
						prev_q    <= ts_q;
						stop_q    <= '0;
						paused_q  <= '0;
						stopped_q <= 1'b0;
						frames_q  <= '0;
						window_q  <= '0;
						fps_q     <= '0;
					end
					OP_START: begin
						if (stopped_q) begin
							prev_q    <= ts_q;
							stop_q    <= '0;
							stopped_q <= 1'b0;
						end
					end
					OP_STOP: begin
						if (!stopped_q) begin
							stop_q    <= ts_q;
							stopped_q <= 1'b1;
						end
					end
					default: begin
						stopped_q <= stopped_q;
					end
				endcase
			end
			// window and pause accumulation
			if (cmd.accum) begin
				if (do_tick_q)
					window_q <= win_sum[TS_W] ? '1 : win_sum[TS_W-1:0];
				if (do_start_q)
					paused_q <= paused_q + span_q;
			end
			// window closes
			if (cmd.check && sts.close) begin
				frames_q <= '0;
				window_q <= '0;
			end
			// held frame rate from the divider
			if (cmd.div_end)
				fps_q <= (den_q == '0) ? '0 : (div_ovf ? FPS_MAX : div_quot);
		end
	end

	// scratch values of the item in flight
	always_ff @(posedge clk) begin
		if (cmd.exec)
			span_q <= ts_q - span_ref;
		if (cmd.accum) begin
			delta_q <= do_tick_q ? span_pos : '0;
			rmb_q   <= (stopped_q ? stop_q : last_tick_q) - base_q;
		end
		if (cmd.check) begin
			total_q <= rmb_q - paused_q;
			prod_q  <= TS_W'(frames_q) * TS_W'(cps);
			den_q   <= window_q;
		end
	end

	// frame rate divider
	pft_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (prod_q),
		.den   (den_q),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (div_quot),
		.ovf   (div_ovf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.finish)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			delta_counts <= delta_q;
			total_counts <= total_q[TS_W-1] ? '0 : total_q;
			fps_fixed    <= fps_q;
			is_paused    <= stopped_q;
		end
	end

	// status to the controller
	always_comb begin
		sts.close    = do_tick_q && (window_q >= TS_W'(cps));
		sts.div_busy = div_busy;
		sts.div_done = div_done;
		sts.out_free = !res_valid_q || res_ready;
	end

	assign res_valid = res_valid_q;

endmodule

// ===== rtl/pft_ctrl.sv =====
// timer controller: sequences one item through the datapath
// depends on: pft_pkg, pausable_frame_timer_top_defines.svh
`include "pausable_frame_timer_top_defines.svh"
module pft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_ready,
	output pft_pkg::pft_cmd_t cmd,
	input  pft_pkg::pft_sts_t sts
);
	import pft_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (evt_valid)
					state_d = S_EXEC;
			end
			S_EXEC:     state_d = S_ACCUM;
			S_ACCUM:    state_d = S_CHECK;
			S_CHECK:    state_d = sts.close ? S_DIVSTART : S_FINISH;
			S_DIVSTART: state_d = S_DIV;
			S_DIV: begin
				if (sts.div_done)
					state_d = S_DIVEND;
			end
			S_DIVEND:   state_d = S_FINISH;
			S_FINISH: begin
				if (sts.out_free)
					state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd       = '0;
		evt_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				evt_ready = 1'b1;
				cmd.load  = evt_valid;
			end
			S_EXEC:     cmd.exec = 1'b1;
			S_ACCUM:    cmd.accum = 1'b1;
			S_CHECK:    cmd.check = 1'b1;
			S_DIVSTART: cmd.div_start = 1'b1;
			S_DIVEND:   cmd.div_end = 1'b1;
			S_FINISH:   cmd.finish = sts.out_free;
			default:    cmd = '0;
		endcase
	end

	// an accepted item always enters execution next
	`PFT_ASSERT_NEXT(a_accept_exec, evt_valid && evt_ready, state_q == S_EXEC, "item not executed")
	// a result is only loaded when the output register can take it
	`PFT_ASSERT_NOW(a_finish_free, cmd.finish, sts.out_free, "result overwrote a pending one")
	// the divider works for the whole wait
	`PFT_ASSERT_NOW(a_div_busy, state_q == S_DIV, sts.div_busy, "waiting on an idle divider")

endmodule

// ===== rtl/pausable_frame_timer_top.sv =====
// pausable frame timer: an accepted item passes through exec, accum and check to finish;
// when a tick closes the frame-rate window, the bit-serial divider runs in between
// one item in flight at a time, and finish waits until the output register is free;
// the next item is taken while the result waits in the output register
// arst_n clears timer state to zero (running) and counts_per_second to 10000000
// depends on: pft_pkg, pft_ctrl, pft_dp
module pausable_frame_timer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pft_pkg::PADDR_W-1:0] paddr,
	input  logic [pft_pkg::PDATA_W-1:0] pwdata,
	output logic [pft_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        evt_valid,
	output logic                        evt_ready,
	input  logic [pft_pkg::OP_W-1:0]    opcode,
	input  logic [pft_pkg::TS_W-1:0]    timestamp,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [pft_pkg::TS_W-1:0]    delta_counts,
	output logic [pft_pkg::TS_W-1:0]    total_counts,
	output logic [pft_pkg::FPS_W-1:0]   fps_fixed,
	output logic                        is_paused
);
	import pft_pkg::*;

	logic [CPS_W-1:0]     cps_q;
	logic [REG_IDX_W-1:0] reg_idx;
	pft_cmd_t             cmd;
	pft_sts_t             sts;

	assign reg_idx = paddr[PADDR_W-1:REG_IDX_LSB];
	assign pready  = 1'b1;

	// configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cps_q <= CPS_RESET;
		else if (psel && penable && pwrite && (reg_idx == REG_CPS))
			cps_q <= pwdata[CPS_W-1:0];
	end

	// configuration read back
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_CPS)
			prdata = PDATA_W'(cps_q);
	end

	pft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pft_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cps         (cps_q),
		.opcode      (opcode),
		.timestamp   (timestamp),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.delta_counts(delta_counts),
		.total_counts(total_counts),
		.fps_fixed   (fps_fixed),
		.is_paused   (is_paused)
	);

endmodule

// ===== test/pausable_frame_timer_top_checker.sv =====
// checker for the pausable frame timer: predicts every result and compares it
// depends on: pft_pkg; watches the item, result and apb channels of the block
`timescale 1ns / 1ps

module pausable_frame_timer_top_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [pft_pkg::PADDR_W-1:0] paddr,
	input  logic [pft_pkg::PDATA_W-1:0] pwdata,
	input  logic [pft_pkg::PDATA_W-1:0] prdata,
	input  logic                        evt_valid,
	input  logic                        evt_ready,
	input  logic [pft_pkg::OP_W-1:0]    opcode,
	input  logic [pft_pkg::TS_W-1:0]    timestamp,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic [pft_pkg::TS_W-1:0]    delta_counts,
	input  logic [pft_pkg::TS_W-1:0]    total_counts,
	input  logic [pft_pkg::FPS_W-1:0]   fps_fixed,
	input  logic                        is_paused,
	output int                          fail_count,
	output int                          pending,
	output int                          results_checked,
	output int                          windows_closed,
	output int                          fps_saturated
);
	import pft_pkg::*;

	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [TS_W-1:0]  delta;
		logic [TS_W-1:0]  total;
		logic [FPS_W-1:0] fps;
		logic             paused;
	} timer_result_t;

	// shadow of the timer state and its frequency register
	logic [CPS_W-1:0] rate;
	logic [TS_W-1:0]  base_ts;
	logic [TS_W-1:0]  prev_ts;
	logic [TS_W-1:0]  last_tick_ts;
	logic [TS_W-1:0]  stop_ts;
	logic [TS_W-1:0]  paused_sum;
	logic             stopped;
	logic [FRM_W-1:0] frames;
	logic [TS_W-1:0]  window_sum;
	logic [FPS_W-1:0] fps_hold;

	timer_result_t timer_results_q[$];

	initial begin
		fail_count      = 0;
		results_checked = 0;
		windows_closed  = 0;
		fps_saturated   = 0;
	end

	task automatic flag_error(input string msg);
		if (fail_count < PRINT_LIMIT)
			$display("%0t checker: %s", $time, msg);
		fail_count++;
	endtask

	// spans with the top bit set are negative and read as zero
	function automatic logic [TS_W-1:0] nonneg(input logic [TS_W-1:0] d);
		return d[TS_W-1] ? '0 : d;
	endfunction

	// (num << frac) / den, truncated, saturating at the top of the fps range
	function automatic logic [FPS_W-1:0] fps_ratio(input logic [TS_W-1:0] num,
		input logic [TS_W-1:0] den);
		logic [TS_W-1:0] q;
		logic [TS_W-1:0] r;
		logic            carry;
		q = num / den;
		r = num % den;
		if (q > TS_W'(FPS_MAX >> FPS_FRAC_BITS))
			return FPS_MAX;
		for (int i = 0; i < FPS_FRAC_BITS; i++) begin
			carry = r[TS_W-1];
			r = r << 1;
			q = q << 1;
			if (carry || r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return q[FPS_W-1:0];
	endfunction

	// apply one event to the shadow state and form the result it yields
	function automatic timer_result_t advance_timer(input op_t op, input logic [TS_W-1:0] ts);
		timer_result_t   res;
		logic [TS_W-1:0] span;
		logic [TS_W-1:0] mark;
		span = '0;
		case (op)
			OP_TICK: begin
				if (!stopped) begin
					last_tick_ts = ts;
					span = nonneg(ts - prev_ts);
					prev_ts = ts;
					if (frames != '1)
						frames++;
					if (window_sum > ~span)
						window_sum = '1;
					else
						window_sum += span;
					// window holds a full second: update the held frame rate
					if (window_sum >= TS_W'(rate)) begin
						fps_hold = (window_sum == '0) ? '0 :
							fps_ratio(TS_W'(frames) * TS_W'(rate), window_sum);
						windows_closed++;
						if (fps_hold == FPS_MAX)
							fps_saturated++;
						frames = '0;
						window_sum = '0;
					end
				end
			end
			OP_RESET: begin
				base_ts = ts;
				prev_ts = ts;
				stop_ts = '0;
				paused_sum = '0;
				stopped = 1'b0;
				frames = '0;
				window_sum = '0;
				fps_hold = '0;
			end
			OP_START: begin
				if (stopped) begin
					paused_sum += ts - stop_ts;
					prev_ts = ts;
					stop_ts = '0;
					stopped = 1'b0;
				end
			end
			default: begin
				if (!stopped) begin
					stop_ts = ts;
					stopped = 1'b1;
				end
			end
		endcase
		mark = stopped ? stop_ts : last_tick_ts;
		res.delta = span;
		res.total = nonneg(mark - base_ts - paused_sum);
		res.fps = fps_hold;
		res.paused = stopped;
		return res;
	endfunction

	// watch the three channels at every rising edge
	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		if (!arst_n) begin
			rate = CPS_RESET;
			base_ts = '0;
			prev_ts = '0;
			last_tick_ts = '0;
			stop_ts = '0;
			paused_sum = '0;
			stopped = 1'b0;
			frames = '0;
			window_sum = '0;
			fps_hold = '0;
			timer_results_q.delete();
			pending <= 0;
		end else begin
			// register accesses
			if (psel && penable && pready &&
				paddr[PADDR_W-1:REG_IDX_LSB] == REG_CPS) begin
				if (pwrite)
					rate = pwdata[CPS_W-1:0];
				else if (prdata[CPS_W-1:0] !== rate)
					flag_error($sformatf("counts_per_second read %0d, expected %0d",
						prdata[CPS_W-1:0], rate));
			end
			// results against the oldest expectation
			if (res_valid && res_ready) begin
				if (timer_results_q.size() == 0) begin
					flag_error("result with no item waiting");
				end else begin
					want = timer_results_q.pop_front();
					results_checked++;
					if (delta_counts !== want.delta)
						flag_error($sformatf("delta_counts %0d, expected %0d",
							delta_counts, want.delta));
					if (total_counts !== want.total)
						flag_error($sformatf("total_counts %0d, expected %0d",
							total_counts, want.total));
					if (fps_fixed !== want.fps)
						flag_error($sformatf("fps_fixed %0d, expected %0d",
							fps_fixed, want.fps));
					if (is_paused !== want.paused)
						flag_error($sformatf("is_paused %0b, expected %0b",
							is_paused, want.paused));
				end
			end
			// accepted items
			if (evt_valid && evt_ready)
				timer_results_q.push_back(advance_timer(op_t'(opcode), timestamp));
			pending <= timer_results_q.size();
		end
	end

endmodule

// ===== test/pausable_frame_timer_top_tb.sv =====
// testbench top for the pausable frame timer: clock, reset, stimulus and verdict
// depends on: pft_pkg, pausable_frame_timer_top, pausable_frame_timer_top_checker
`timescale 1ns / 1ps

module pausable_frame_timer_top_tb;
	import pft_pkg::*;

	localparam int CLK_PERIOD        = 10;
	localparam int RESET_CYCLES      = 4;
	localparam int HOLD_OFF_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT    = 4000;
	localparam int SETTLE_CYCLES     = 100;
	localparam int ITEMS_PER_SETTING = 130;
	localparam int ZERO_RATE_ITEMS   = 40;
	localparam int NUM_SETTINGS      = 6;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               evt_valid = 1'b0;
	logic               evt_ready;
	logic [OP_W-1:0]    opcode = '0;
	logic [TS_W-1:0]    timestamp = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	logic [TS_W-1:0]    delta_counts;
	logic [TS_W-1:0]    total_counts;
	logic [FPS_W-1:0]   fps_fixed;
	logic               is_paused;

	int fail_count;
	int pending;
	int results_checked;
	int windows_closed;
	int fps_saturated;

	// stimulus bookkeeping
	logic [TS_W-1:0]  stamp_now = '0;
	logic [CPS_W-1:0] rate = CPS_RESET;
	logic             hold_off_req = 1'b0;
	int               items_sent = 0;
	int               settings_used = 1;
	int               idle_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	pausable_frame_timer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.evt_valid    (evt_valid),
		.evt_ready    (evt_ready),
		.opcode       (opcode),
		.timestamp    (timestamp),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.delta_counts (delta_counts),
		.total_counts (total_counts),
		.fps_fixed    (fps_fixed),
		.is_paused    (is_paused)
	);

	pausable_frame_timer_top_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.evt_valid       (evt_valid),
		.evt_ready       (evt_ready),
		.opcode          (opcode),
		.timestamp       (timestamp),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.delta_counts    (delta_counts),
		.total_counts    (total_counts),
		.fps_fixed       (fps_fixed),
		.is_paused       (is_paused),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.windows_closed  (windows_closed),
		.fps_saturated   (fps_saturated)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// next counter value: mostly spans from about 1/32 of a second up to two seconds,
	// sometimes a jump anywhere, a step backwards or no movement
	function automatic logic [TS_W-1:0] next_stamp();
		logic [TS_W-1:0] span;
		int unsigned     pick;
		pick = $urandom_range(0, 99);
		span = ((TS_W'(rate) + 1) * TS_W'($urandom_range(1, 64))) >> 5;
		span += TS_W'($urandom_range(0, 15));
		if (pick < 3)
			span = {$urandom, $urandom};
		else if (pick < 6)
			span = -TS_W'($urandom_range(1, 5000));
		else if (pick < 10)
			span = '0;
		stamp_now += span;
		return stamp_now;
	endfunction

	// offer one item and hold it until it is taken
	task automatic send_item(input op_t op, input logic [TS_W-1:0] ts);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		opcode <= op;
		timestamp <= ts;
		do @(posedge clk); while (!evt_ready);
		items_sent++;
	endtask

	// stop offering and wait until every expected result has come back
	task automatic drain();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// apb access: a setup phase, then an access phase
	task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
		input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, {REG_IDX_LSB{1'b0}}};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// a random op mix of mostly ticks with stop, start and reset
	task automatic send_random();
		int unsigned r;
		op_t         op;
		r = $urandom_range(0, 99);
		if (r < 4)
			op = OP_RESET;
		else if (r < 12)
			op = OP_STOP;
		else if (r < 20)
			op = OP_START;
		else
			op = OP_TICK;
		send_item(op, next_stamp());
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			n = pick_gap();
			if (n > 0) begin
				res_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_valid && evt_ready) || (res_valid && res_ready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, pending);
				$display("pausable_frame_timer_top_tb: errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [CPS_W-1:0] rate_plan [NUM_SETTINGS];
		int               count;
		rate_plan = '{32'd1, 32'd0, 32'hFFFF_FFFF, CPS_W'($urandom_range(2, 1000)),
			$urandom, CPS_RESET};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed events at the reset frequency
		send_item(OP_TICK, 64'd0);
		send_item(OP_RESET, 64'd1000);
		send_item(OP_TICK, 64'd4_001_000);
		send_item(OP_TICK, 64'd8_001_000);
		send_item(OP_TICK, 64'd12_001_000);
		// stop, tick while stopped, second stop, start, second start
		send_item(OP_STOP, 64'd12_500_000);
		send_item(OP_TICK, 64'd12_600_000);
		send_item(OP_STOP, 64'd12_700_000);
		send_item(OP_START, 64'd13_500_000);
		send_item(OP_START, 64'd13_600_000);
		send_item(OP_TICK, 64'd14_000_000);
		// counter moving backwards
		send_item(OP_TICK, 64'd13_999_500);
		send_item(OP_RESET, 64'd5000);
		// counter wrap and extremes of the timestamp
		send_item(OP_TICK, 64'hFFFF_FFFF_FFFF_FFF0);
		send_item(OP_TICK, 64'd5);
		send_item(OP_TICK, '1);
		send_item(OP_STOP, 64'hFFFF_FFFF_FFFF_FF00);
		send_item(OP_START, 64'd10);
		send_item(OP_TICK, 64'd20_000_000);
		// reset while stopped
		send_item(OP_STOP, 64'd20_100_000);
		send_item(OP_RESET, 64'd20_200_000);
		send_item(OP_TICK, 64'd20_300_000);
		stamp_now = 64'd20_300_000;

		// one random phase per frequency setting, written only when idle
		for (int p = 0; p < NUM_SETTINGS; p++) begin
			drain();
			rate = rate_plan[p];
			apb_access(1'b1, REG_CPS, PDATA_W'(rate));
			apb_access(1'b0, REG_CPS, '0);
			settings_used++;
			send_item(OP_RESET, next_stamp());

			count = (rate == '0) ? ZERO_RATE_ITEMS : ITEMS_PER_SETTING;
			for (int i = 0; i < count; i++) begin
				if (p == 2 && i == 60)
					hold_off_req = 1'b1;
				send_random();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d events across %0d frequency settings, %0d results checked",
			items_sent, settings_used, results_checked);
		$display("%0d frame-rate windows closed, %0d with a saturated rate",
			windows_closed, fps_saturated);
		if (fail_count == 0)
			$display("pausable_frame_timer_top_tb: clean");
		else
			$display("pausable_frame_timer_top_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pft_pkg.sv
rtl/pft_div.sv
rtl/pft_dp.sv
rtl/pft_ctrl.sv
rtl/pausable_frame_timer_top.sv
test/pausable_frame_timer_top_checker.sv
test/pausable_frame_timer_top_tb.sv
